// ----- sv/ctoi_pkg.sv -----
// Package for the circle pair time-of-impact block: widths, lane types and constants.
`timescale 1ns / 1ps

package ctoi_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 8;
  localparam int TIME_FRAC_BITS  = 16;
  localparam int IN_W            = 24;
  localparam int RAD_W           = 10;
  localparam int TIME_W          = 24;

  // Derived datapath widths
  localparam int DIF_W  = IN_W + 1;
  localparam int R_W    = RAD_W + 1 + COORD_FRAC_BITS;
  localparam int P_W    = 2 * DIF_W;
  localparam int A_W    = P_W;
  localparam int H_W    = P_W + 1;
  localparam int C_W    = P_W + 1;
  localparam int MAG_W  = P_W;
  localparam int SPL_W  = (MAG_W + 1) / 2;
  localparam int SPH_W  = MAG_W - SPL_W;
  localparam int HH_W   = 2 * MAG_W;
  localparam int D_W    = HH_W + 2;
  localparam int S_W    = D_W / 2;
  localparam int SR_W   = S_W + 2;
  localparam int N_W    = S_W + 1;
  localparam int Q_W    = N_W + TIME_FRAC_BITS;
  localparam int DR_W   = A_W + 1;
  localparam int SK_W   = S_W + TIME_FRAC_BITS;
  localparam int SSL_W  = (S_W + 1) / 2;
  localparam int SSH_W  = S_W - SSL_W;
  localparam int RH_W   = S_W + 2 * TIME_FRAC_BITS + 2;
  localparam int DL_W   = D_W + 2 * TIME_FRAC_BITS;

  // One input pair as seen by the front end
  typedef struct packed {
    logic signed [IN_W-1:0]  first_x;
    logic signed [IN_W-1:0]  first_y;
    logic signed [IN_W-1:0]  first_vel_x;
    logic signed [IN_W-1:0]  first_vel_y;
    logic        [RAD_W-1:0] first_radius;
    logic signed [IN_W-1:0]  second_x;
    logic signed [IN_W-1:0]  second_y;
    logic signed [IN_W-1:0]  second_vel_x;
    logic signed [IN_W-1:0]  second_vel_y;
    logic        [RAD_W-1:0] second_radius;
  } ctoi_pair_t;

  // Lane carried through the square root cells
  typedef struct packed {
    logic                    miss;
    logic        [A_W-1:0]   a;
    logic signed [H_W-1:0]   h;
    logic        [D_W-1:0]   d;
    logic        [SR_W-1:0]  rem;
    logic        [S_W-1:0]   root;
  } ctoi_sq_t;

  // Lane carried through the divider cells
  typedef struct packed {
    logic                    miss;
    logic                    first;
    logic        [A_W-1:0]   a;
    logic        [D_W-1:0]   d;
    logic        [SR_W-1:0]  e;
    logic        [S_W-1:0]   s;
    logic        [Q_W-1:0]   numer;
    logic        [DR_W-1:0]  drem;
    logic        [TIME_W-1:0] quot;
    logic                    qsat;
  } ctoi_dv_t;

endpackage

// ----- sv/ctoi_in_if.sv -----
// Input channel carrying one disk pair.
`timescale 1ns / 1ps

interface ctoi_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ctoi_pkg::IN_W-1:0]    first_x;
  logic signed [ctoi_pkg::IN_W-1:0]    first_y;
  logic signed [ctoi_pkg::IN_W-1:0]    first_vel_x;
  logic signed [ctoi_pkg::IN_W-1:0]    first_vel_y;
  logic        [ctoi_pkg::RAD_W-1:0]   first_radius;
  logic signed [ctoi_pkg::IN_W-1:0]    second_x;
  logic signed [ctoi_pkg::IN_W-1:0]    second_y;
  logic signed [ctoi_pkg::IN_W-1:0]    second_vel_x;
  logic signed [ctoi_pkg::IN_W-1:0]    second_vel_y;
  logic        [ctoi_pkg::RAD_W-1:0]   second_radius;

  modport source (
    output valid, first_x, first_y, first_vel_x, first_vel_y, first_radius,
           second_x, second_y, second_vel_x, second_vel_y, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_vel_x, first_vel_y, first_radius,
           second_x, second_y, second_vel_x, second_vel_y, second_radius,
    output ready
  );
endinterface

// ----- sv/ctoi_out_if.sv -----
// Output channel carrying one contact result.
`timescale 1ns / 1ps

interface ctoi_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [ctoi_pkg::TIME_W-1:0]        contact_time;

  modport source (output valid, hit, contact_time, input ready);
  modport sink (input valid, hit, contact_time, output ready);
endinterface

// ----- sv/ctoi_front.sv -----
// Front end: relative motion, quadratic coefficients and discriminant.
`timescale 1ns / 1ps

module ctoi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  ctoi_pkg::ctoi_pair_t pair_i,
  output logic                vld_o,
  output ctoi_pkg::ctoi_sq_t  lane_o
);

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld_q;

  // stage 0
  logic signed [ctoi_pkg::DIF_W-1:0] dx_q, dy_q, wx_q, wy_q;
  logic        [ctoi_pkg::R_W-1:0]   rs_q;
  logic        [ctoi_pkg::RAD_W:0]   rsum;
  // stage 1
  logic signed [ctoi_pkg::P_W-1:0]   pxw_q, pyw_q, pwx_q, pwy_q, pdx_q, pdy_q;
  logic        [2*ctoi_pkg::R_W-1:0] prr_q;
  // stage 2
  logic        [ctoi_pkg::A_W-1:0]   a2_q;
  logic signed [ctoi_pkg::H_W-1:0]   h2_q;
  logic signed [ctoi_pkg::C_W-1:0]   c2_q;
  // stage 3
  logic        [ctoi_pkg::A_W-1:0]   a3_q;
  logic signed [ctoi_pkg::H_W-1:0]   h3_q;
  logic        [ctoi_pkg::MAG_W-1:0] ha3_q, ca3_q;
  logic                              cneg3_q, miss3_q;
  // stage 4
  logic        [ctoi_pkg::A_W-1:0]   a4_q;
  logic signed [ctoi_pkg::H_W-1:0]   h4_q;
  logic                              cneg4_q, miss4_q;
  logic [2*ctoi_pkg::SPL_W-1:0]                hll_q, all_q;
  logic [ctoi_pkg::SPL_W+ctoi_pkg::SPH_W-1:0]  hlh_q, alh_q, ahl_q;
  logic [2*ctoi_pkg::SPH_W-1:0]                hhh_q, ahh_q;
  // stage 5
  logic        [ctoi_pkg::A_W-1:0]   a5_q;
  logic signed [ctoi_pkg::H_W-1:0]   h5_q;
  logic                              cneg5_q, miss5_q;
  logic        [ctoi_pkg::HH_W-1:0]  hh5_q, ac5_q;
  // stage 6
  ctoi_pkg::ctoi_sq_t                lane_q;

  assign rsum = {1'b0, pair_i.first_radius} + {1'b0, pair_i.second_radius};

  // advance the valid bits with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  // form relative position, velocity and radius sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= $signed({pair_i.second_x[ctoi_pkg::IN_W-1], pair_i.second_x})
            - $signed({pair_i.first_x[ctoi_pkg::IN_W-1], pair_i.first_x});
      dy_q <= $signed({pair_i.second_y[ctoi_pkg::IN_W-1], pair_i.second_y})
            - $signed({pair_i.first_y[ctoi_pkg::IN_W-1], pair_i.first_y});
      wx_q <= $signed({pair_i.second_vel_x[ctoi_pkg::IN_W-1], pair_i.second_vel_x})
            - $signed({pair_i.first_vel_x[ctoi_pkg::IN_W-1], pair_i.first_vel_x});
      wy_q <= $signed({pair_i.second_vel_y[ctoi_pkg::IN_W-1], pair_i.second_vel_y})
            - $signed({pair_i.first_vel_y[ctoi_pkg::IN_W-1], pair_i.first_vel_y});
      rs_q <= ctoi_pkg::R_W'(rsum) << ctoi_pkg::COORD_FRAC_BITS;
    end
  end

  // multiply the component products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxw_q <= dx_q * wx_q;
      pyw_q <= dy_q * wy_q;
      pwx_q <= wx_q * wx_q;
      pwy_q <= wy_q * wy_q;
      pdx_q <= dx_q * dx_q;
      pdy_q <= dy_q * dy_q;
      prr_q <= rs_q * rs_q;
    end
  end

  // sum into a, h and c
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q <= ctoi_pkg::A_W'($unsigned(pwx_q) + $unsigned(pwy_q));
      h2_q <= ctoi_pkg::H_W'(pxw_q) + ctoi_pkg::H_W'(pyw_q);
      c2_q <= ctoi_pkg::C_W'(pdx_q) + ctoi_pkg::C_W'(pdy_q) - ctoi_pkg::C_W'(prr_q);
    end
  end

  // take magnitudes, flag zero relative motion
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q    <= a2_q;
      h3_q    <= h2_q;
      ha3_q   <= ctoi_pkg::MAG_W'(h2_q < 0 ? -h2_q : h2_q);
      ca3_q   <= ctoi_pkg::MAG_W'(c2_q < 0 ? -c2_q : c2_q);
      cneg3_q <= c2_q < 0;
      miss3_q <= a2_q == '0;
    end
  end

  // partial products of h*h and a*c
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a4_q    <= a3_q;
      h4_q    <= h3_q;
      cneg4_q <= cneg3_q;
      miss4_q <= miss3_q;
      hll_q   <= ha3_q[ctoi_pkg::SPL_W-1:0] * ha3_q[ctoi_pkg::SPL_W-1:0];
      hlh_q   <= ha3_q[ctoi_pkg::SPL_W-1:0] * ha3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W];
      hhh_q   <= ha3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W]
               * ha3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W];
      all_q   <= a3_q[ctoi_pkg::SPL_W-1:0] * ca3_q[ctoi_pkg::SPL_W-1:0];
      alh_q   <= a3_q[ctoi_pkg::SPL_W-1:0] * ca3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W];
      ahl_q   <= a3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W] * ca3_q[ctoi_pkg::SPL_W-1:0];
      ahh_q   <= a3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W]
               * ca3_q[ctoi_pkg::MAG_W-1:ctoi_pkg::SPL_W];
    end
  end

  // combine partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a5_q    <= a4_q;
      h5_q    <= h4_q;
      cneg5_q <= cneg4_q;
      miss5_q <= miss4_q;
      hh5_q   <= ctoi_pkg::HH_W'(hll_q)
               + (ctoi_pkg::HH_W'(hlh_q) << (ctoi_pkg::SPL_W + 1))
               + (ctoi_pkg::HH_W'(hhh_q) << (2 * ctoi_pkg::SPL_W));
      ac5_q   <= ctoi_pkg::HH_W'(all_q)
               + (ctoi_pkg::HH_W'(alh_q) << ctoi_pkg::SPL_W)
               + (ctoi_pkg::HH_W'(ahl_q) << ctoi_pkg::SPL_W)
               + (ctoi_pkg::HH_W'(ahh_q) << (2 * ctoi_pkg::SPL_W));
    end
  end

  // discriminant, drop pairs with a negative one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q.miss <= miss5_q | (!cneg5_q && (hh5_q < ac5_q));
      lane_q.a    <= a5_q;
      lane_q.h    <= h5_q;
      lane_q.d    <= cneg5_q ? ctoi_pkg::D_W'(hh5_q) + ctoi_pkg::D_W'(ac5_q)
                             : ctoi_pkg::D_W'(hh5_q) - ctoi_pkg::D_W'(ac5_q);
      lane_q.rem  <= '0;
      lane_q.root <= '0;
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign lane_o = lane_q;

endmodule

// ----- sv/ctoi_sqrt_cell.sv -----
// Square root cell: settles one root bit from the next two discriminant bits.
`timescale 1ns / 1ps

module ctoi_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  ctoi_pkg::ctoi_sq_t lane_i,
  output logic               vld_o,
  output ctoi_pkg::ctoi_sq_t lane_o
);

  logic [ctoi_pkg::SR_W-1:0] trial, part;
  logic                      ge;
  ctoi_pkg::ctoi_sq_t        lane_d, lane_q;
  logic                      vld_q;

  // trial subtract and rotate the radicand to its next pair
  always_comb begin
    trial       = {lane_i.root, 2'b01};
    part        = {lane_i.rem[ctoi_pkg::SR_W-3:0], lane_i.d[ctoi_pkg::D_W-1 -: 2]};
    ge          = part >= trial;
    lane_d      = lane_i;
    lane_d.rem  = ge ? part - trial : part;
    lane_d.root = {lane_i.root[ctoi_pkg::S_W-2:0], ge};
    lane_d.d    = {lane_i.d[ctoi_pkg::D_W-3:0], lane_i.d[ctoi_pkg::D_W-1 -: 2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

// ----- sv/ctoi_div_cell.sv -----
// Divider cell: one restoring division step of the root numerator by a.
`timescale 1ns / 1ps

module ctoi_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  ctoi_pkg::ctoi_dv_t lane_i,
  output logic               vld_o,
  output ctoi_pkg::ctoi_dv_t lane_o
);

  logic [ctoi_pkg::DR_W-1:0] part, dvs;
  logic                      ge;
  ctoi_pkg::ctoi_dv_t        lane_d, lane_q;
  logic                      vld_q;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    dvs          = {1'b0, lane_i.a};
    part         = {lane_i.drem[ctoi_pkg::A_W-1:0], lane_i.numer[ctoi_pkg::Q_W-1]};
    ge           = part >= dvs;
    lane_d       = lane_i;
    lane_d.drem  = ge ? part - dvs : part;
    lane_d.quot  = {lane_i.quot[ctoi_pkg::TIME_W-2:0], ge};
    lane_d.qsat  = lane_i.qsat | lane_i.quot[ctoi_pkg::TIME_W-1];
    lane_d.numer = {lane_i.numer[ctoi_pkg::Q_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

// ----- sv/ctoi_check.sv -----
// Overlap check one time LSB after the chosen root, and result formatting.
`timescale 1ns / 1ps

module ctoi_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  ctoi_pkg::ctoi_dv_t            lane_i,
  output logic                          vld_o,
  output logic                          hit_o,
  output logic [ctoi_pkg::TIME_W-1:0]   time_o
);

  localparam int TF   = ctoi_pkg::TIME_FRAC_BITS;
  localparam int NSTG = 4;

  logic [NSTG-1:0] vld_q;

  // stage 0
  logic [ctoi_pkg::A_W-1:0]    k_c, m_c;
  logic [ctoi_pkg::SK_W-1:0]   sk_c;
  logic [ctoi_pkg::A_W-1:0]    m0_q;
  logic [TF-1:0]               kl0_q;
  logic                        sge0_q, klg0_q;
  ctoi_pkg::ctoi_dv_t          l0_q;
  // stage 1
  logic [2*ctoi_pkg::SPL_W-1:0]                 mll_q;
  logic [ctoi_pkg::SPL_W+ctoi_pkg::SPH_W-1:0]   mlh_q;
  logic [2*ctoi_pkg::SPH_W-1:0]                 mhh_q;
  logic [ctoi_pkg::SSL_W+TF-1:0]                psl_q;
  logic [ctoi_pkg::SSH_W+TF-1:0]                psh_q;
  logic [2*TF-1:0]                              kk_q;
  logic                        sge1_q, klg1_q;
  ctoi_pkg::ctoi_dv_t          l1_q;
  // stage 2
  logic [ctoi_pkg::HH_W-1:0]   mm2_q;
  logic [ctoi_pkg::RH_W-1:0]   rhs2_q;
  logic                        sge2_q, klg2_q;
  ctoi_pkg::ctoi_dv_t          l2_q;
  // stage 3
  logic                        ok_c;
  logic                        hit_q;
  logic [ctoi_pkg::TIME_W-1:0] time_q;

  // advance the valid bits with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  // distance to the next multiple of a, and the root scaled to time units
  always_comb begin
    k_c  = lane_i.a - lane_i.drem[ctoi_pkg::A_W-1:0];
    sk_c = ctoi_pkg::SK_W'(lane_i.s) << TF;
    m_c  = k_c - ctoi_pkg::A_W'(sk_c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l0_q   <= lane_i;
      m0_q   <= m_c;
      kl0_q  <= k_c[TF-1:0];
      sge0_q <= sk_c >= ctoi_pkg::SK_W'(k_c);
      klg0_q <= |k_c[ctoi_pkg::A_W-1:TF];
    end
  end

  // partial products for both branch tests
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_q   <= l0_q;
      sge1_q <= sge0_q;
      klg1_q <= klg0_q;
      mll_q  <= m0_q[ctoi_pkg::SPL_W-1:0] * m0_q[ctoi_pkg::SPL_W-1:0];
      mlh_q  <= m0_q[ctoi_pkg::SPL_W-1:0] * m0_q[ctoi_pkg::A_W-1:ctoi_pkg::SPL_W];
      mhh_q  <= m0_q[ctoi_pkg::A_W-1:ctoi_pkg::SPL_W] * m0_q[ctoi_pkg::A_W-1:ctoi_pkg::SPL_W];
      psl_q  <= l0_q.s[ctoi_pkg::SSL_W-1:0] * kl0_q;
      psh_q  <= l0_q.s[ctoi_pkg::S_W-1:ctoi_pkg::SSL_W] * kl0_q;
      kk_q   <= kl0_q * kl0_q;
    end
  end

  // combine partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l2_q   <= l1_q;
      sge2_q <= sge1_q;
      klg2_q <= klg1_q;
      mm2_q  <= ctoi_pkg::HH_W'(mll_q)
              + (ctoi_pkg::HH_W'(mlh_q) << (ctoi_pkg::SPL_W + 1))
              + (ctoi_pkg::HH_W'(mhh_q) << (2 * ctoi_pkg::SPL_W));
      rhs2_q <= ((ctoi_pkg::RH_W'(psl_q) + (ctoi_pkg::RH_W'(psh_q) << ctoi_pkg::SSL_W))
                 << (TF + 1)) + ctoi_pkg::RH_W'(kk_q);
    end
  end

  // smaller root passes if still inside, larger root only if not yet out
  always_comb begin
    if (l2_q.first) begin
      ok_c = sge2_q
          || (ctoi_pkg::DL_W'(mm2_q) <= (ctoi_pkg::DL_W'(l2_q.d) << (2 * TF)));
    end else begin
      ok_c = !klg2_q && ((ctoi_pkg::RH_W'(l2_q.e) << (2 * TF)) >= rhs2_q);
    end
  end

  // saturate accepted times, zero the rest
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= !l2_q.miss && ok_c;
      time_q <= (!l2_q.miss && ok_c) ? (l2_q.qsat ? '1 : l2_q.quot) : '0;
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign hit_o  = hit_q;
  assign time_o = time_q;

endmodule

// ----- sv/circle_pair_time_of_impact_top.sv -----
// Top level of the circle pair time-of-impact block.
// Usage:
//   pair_i carries the centers, velocities and radii of two disks; toi_o
//   returns hit and contact_time (Q8.16 seconds, saturated, zero on no hit).
//   Both are valid/ready channels; a transfer happens when both are high.
// Path from an input transfer to the result transfer on toi_o:
//   7 front stages (differences, products, sums, discriminant), 51 square
//   root cells, one root select stage, 68 divider cells, 4 check stages and
//   the output queue register.
// Throughput: one pair per cycle while the output queue has room; every cell
//   hands its lane to the next as the chain advances, the square root and divider chains resolving one bit a cell.
// Stalls: results land in a two-entry output queue. The whole chain advances
//   while the queue is not full, so a new pair is taken while a result waits;
//   with the queue full, ready drops and the chain holds until a transfer.
// Reset: rst_ni clears all valid bits and the queue; no results are pending.
`timescale 1ns / 1ps

module circle_pair_time_of_impact_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctoi_in_if.sink    pair_i,
  ctoi_out_if.source toi_o
);

  localparam logic [1:0] FIFO_FULL = 2'd2;

  logic                        en;
  ctoi_pkg::ctoi_pair_t        pair;

  logic                        sq_vld  [ctoi_pkg::S_W+1];
  ctoi_pkg::ctoi_sq_t          sq_lane [ctoi_pkg::S_W+1];
  logic                        dv_vld  [ctoi_pkg::Q_W+1];
  ctoi_pkg::ctoi_dv_t          dv_lane [ctoi_pkg::Q_W+1];

  logic signed [ctoi_pkg::N_W:0] hx, sx, n1, n2;
  logic                        ns_vld_q;
  ctoi_pkg::ctoi_dv_t          ns_lane_q;

  logic                        chk_vld, chk_hit;
  logic [ctoi_pkg::TIME_W-1:0] chk_time;

  logic                        fifo_hit_q  [2];
  logic [ctoi_pkg::TIME_W-1:0] fifo_time_q [2];
  logic                        wptr_q, rptr_q;
  logic [1:0]                  cnt_q;
  logic                        push, pop;

  // advance the chain while the output queue has room
  assign en           = cnt_q != FIFO_FULL;
  assign pair_i.ready = en;

  assign pair.first_x       = pair_i.first_x;
  assign pair.first_y       = pair_i.first_y;
  assign pair.first_vel_x   = pair_i.first_vel_x;
  assign pair.first_vel_y   = pair_i.first_vel_y;
  assign pair.first_radius  = pair_i.first_radius;
  assign pair.second_x      = pair_i.second_x;
  assign pair.second_y      = pair_i.second_y;
  assign pair.second_vel_x  = pair_i.second_vel_x;
  assign pair.second_vel_y  = pair_i.second_vel_y;
  assign pair.second_radius = pair_i.second_radius;

  ctoi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pair_i.valid),
    .pair_i (pair),
    .vld_o  (sq_vld[0]),
    .lane_o (sq_lane[0])
  );

  // square root chain
  for (genvar gi = 0; gi < ctoi_pkg::S_W; gi++) begin : g_sqrt
    ctoi_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[gi]),
      .lane_i (sq_lane[gi]),
      .vld_o  (sq_vld[gi+1]),
      .lane_o (sq_lane[gi+1])
    );
  end

  // pick the root numerator: smaller root if non-negative, else the larger
  always_comb begin
    hx = (ctoi_pkg::N_W+1)'(sq_lane[ctoi_pkg::S_W].h);
    sx = $signed((ctoi_pkg::N_W+1)'(sq_lane[ctoi_pkg::S_W].root));
    n1 = -hx - sx;
    n2 = -hx + sx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_vld_q <= 1'b0;
    end else if (en) begin
      ns_vld_q <= sq_vld[ctoi_pkg::S_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ns_lane_q.miss  <= sq_lane[ctoi_pkg::S_W].miss | (n1[ctoi_pkg::N_W] & n2[ctoi_pkg::N_W]);
      ns_lane_q.first <= !n1[ctoi_pkg::N_W];
      ns_lane_q.a     <= sq_lane[ctoi_pkg::S_W].a;
      ns_lane_q.d     <= sq_lane[ctoi_pkg::S_W].d;
      ns_lane_q.e     <= sq_lane[ctoi_pkg::S_W].rem;
      ns_lane_q.s     <= sq_lane[ctoi_pkg::S_W].root;
      ns_lane_q.numer <= ctoi_pkg::Q_W'(n1[ctoi_pkg::N_W] ? n2[ctoi_pkg::N_W-1:0]
                                                          : n1[ctoi_pkg::N_W-1:0])
                         << ctoi_pkg::TIME_FRAC_BITS;
      ns_lane_q.drem  <= '0;
      ns_lane_q.quot  <= '0;
      ns_lane_q.qsat  <= 1'b0;
    end
  end

  assign dv_vld[0]  = ns_vld_q;
  assign dv_lane[0] = ns_lane_q;

  // divider chain
  for (genvar gj = 0; gj < ctoi_pkg::Q_W; gj++) begin : g_div
    ctoi_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[gj]),
      .lane_i (dv_lane[gj]),
      .vld_o  (dv_vld[gj+1]),
      .lane_o (dv_lane[gj+1])
    );
  end

  ctoi_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld[ctoi_pkg::Q_W]),
    .lane_i (dv_lane[ctoi_pkg::Q_W]),
    .vld_o  (chk_vld),
    .hit_o  (chk_hit),
    .time_o (chk_time)
  );

  // output queue
  assign push = en && chk_vld;
  assign pop  = toi_o.valid && toi_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_hit_q[wptr_q]  <= chk_hit;
      fifo_time_q[wptr_q] <= chk_time;
    end
  end

  assign toi_o.valid        = cnt_q != '0;
  assign toi_o.hit          = fifo_hit_q[rptr_q];
  assign toi_o.contact_time = fifo_time_q[rptr_q];

endmodule

// ----- tb/circle_pair_time_of_impact_top_tb.sv -----
// Self-checking testbench for the circle pair time-of-impact block.
`timescale 1ns / 1ps

module circle_pair_time_of_impact_top_tb;

  localparam int  NUM_RANDOM  = 1750;
  localparam int  DRAIN_WAIT  = 150;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [ctoi_pkg::TIME_W-1:0] TIME_SAT = '1;

  typedef struct {
    logic                        hit;
    logic [ctoi_pkg::TIME_W-1:0] contact_time;
  } contact_t;

  typedef struct {
    ctoi_pkg::ctoi_pair_t        pair;
    bit                          known;
    logic                        hit;
    logic [ctoi_pkg::TIME_W-1:0] contact_time;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ctoi_in_if  pair_if ();
  ctoi_out_if toi_if ();

  circle_pair_time_of_impact_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair_if.sink),
    .toi_o  (toi_if.source)
  );

  contact_t  contact_q[$];
  stim_row_t row_q[$];
  int        error_cnt = 0;
  int        pair_cnt  = 0;
  int        hit_cnt   = 0;
  int        sat_cnt   = 0;
  longint    cycle_cnt = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Compute the expected contact of one disk pair
  function automatic contact_t predict_contact(ctoi_pkg::ctoi_pair_t p);
    longint dx, dy, wx, wy, rs, av, hv, cv;
    logic [255:0] a, ha, ca, hh, ac, d, s, cand, n, qi, r, frac, k, need, m, e, lhs, rhs;
    logic signed [127:0] n1, n2;
    bit first, ok;
    contact_t res;
    dx = longint'(p.second_x) - longint'(p.first_x);
    dy = longint'(p.second_y) - longint'(p.first_y);
    wx = longint'(p.second_vel_x) - longint'(p.first_vel_x);
    wy = longint'(p.second_vel_y) - longint'(p.first_vel_y);
    rs = (longint'(p.first_radius) + longint'(p.second_radius)) <<< ctoi_pkg::COORD_FRAC_BITS;
    av = wx * wx + wy * wy;
    hv = dx * wx + dy * wy;
    cv = dx * dx + dy * dy - rs * rs;
    res.hit = 1'b0;
    res.contact_time = '0;
    if (av == 0) return res;
    a  = 256'(av);
    ha = 256'(hv < 0 ? -hv : hv);
    ca = 256'(cv < 0 ? -cv : cv);
    hh = ha * ha;
    ac = a * ca;
    if (cv >= 0) begin
      if (hh < ac) return res;
      d = hh - ac;
    end else begin
      d = hh + ac;
    end
    // Floor square root, one bit at a time
    s = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = s | (256'd1 << b);
      if (cand * cand <= d) s = cand;
    end
    n1 = -128'(hv) - 128'(s);
    n2 = -128'(hv) + 128'(s);
    if (n1 >= 0) begin
      first = 1'b1;
      n = 256'(n1);
    end else if (n2 >= 0) begin
      first = 1'b0;
      n = 256'(n2);
    end else begin
      return res;
    end
    qi = n / a;
    r = n % a;
    frac = '0;
    for (int i = 0; i < ctoi_pkg::TIME_FRAC_BITS; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= a) begin
        r = r - a;
        frac[0] = 1'b1;
      end
    end
    k = a - r;
    // Overlap one time LSB after the chosen root
    if (first) begin
      need = (k + (256'd1 << ctoi_pkg::TIME_FRAC_BITS) - 1) >> ctoi_pkg::TIME_FRAC_BITS;
      if (s >= need) begin
        ok = 1'b1;
      end else begin
        m = k - (s << ctoi_pkg::TIME_FRAC_BITS);
        if ((d >> (128 - 2 * ctoi_pkg::TIME_FRAC_BITS)) != 0) ok = 1'b1;
        else ok = (m * m) <= (d << (2 * ctoi_pkg::TIME_FRAC_BITS));
      end
    end else begin
      if (k >= (256'd1 << ctoi_pkg::TIME_FRAC_BITS)) begin
        ok = 1'b0;
      end else begin
        e   = d - s * s;
        lhs = e << (2 * ctoi_pkg::TIME_FRAC_BITS);
        rhs = s * (k << (ctoi_pkg::TIME_FRAC_BITS + 1)) + k * k;
        ok  = lhs >= rhs;
      end
    end
    if (!ok) return res;
    res.hit = 1'b1;
    if ((qi >> (ctoi_pkg::TIME_W - ctoi_pkg::TIME_FRAC_BITS)) != 0) begin
      res.contact_time = TIME_SAT;
    end else begin
      res.contact_time = ctoi_pkg::TIME_W'((qi << ctoi_pkg::TIME_FRAC_BITS) | frac);
    end
    return res;
  endfunction

  function automatic ctoi_pkg::ctoi_pair_t make_pair(int fx, int fy, int fvx, int fvy, int fr,
                                                     int sx, int sy, int svx, int svy, int sr);
    ctoi_pkg::ctoi_pair_t p;
    p.first_x  = ctoi_pkg::IN_W'(fx);  p.first_y  = ctoi_pkg::IN_W'(fy);
    p.first_vel_x = ctoi_pkg::IN_W'(fvx); p.first_vel_y = ctoi_pkg::IN_W'(fvy);
    p.first_radius = ctoi_pkg::RAD_W'(fr);
    p.second_x = ctoi_pkg::IN_W'(sx);  p.second_y = ctoi_pkg::IN_W'(sy);
    p.second_vel_x = ctoi_pkg::IN_W'(svx); p.second_vel_y = ctoi_pkg::IN_W'(svy);
    p.second_radius = ctoi_pkg::RAD_W'(sr);
    return p;
  endfunction

  function automatic int rand_signed(int span);
    return $urandom_range(2 * span, 0) - span;
  endfunction

  // Draw a random pair: mostly nearby disks with moderate speeds, some raw noise
  function automatic ctoi_pkg::ctoi_pair_t random_pair();
    ctoi_pkg::ctoi_pair_t p;
    logic [223:0] raw;
    int sel, fx, fy, fvx, fvy, span;
    sel = $urandom_range(9, 0);
    if (sel < 2) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[$bits(ctoi_pkg::ctoi_pair_t)-1:0];
    end else begin
      span = (sel < 5) ? 4096 : 1 << 16;
      fx  = rand_signed(1 << 22);
      fy  = rand_signed(1 << 22);
      fvx = rand_signed(span);
      fvy = rand_signed(span);
      p = make_pair(fx, fy, fvx, fvy, $urandom_range(1023, 0),
                    fx + rand_signed(span * 4), fy + rand_signed(span * 4),
                    fvx + rand_signed(span), fvy + rand_signed(span),
                    $urandom_range(1023, 0));
    end
    return p;
  endfunction

  function automatic int gap_length();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Directed rows: fixed answers only where they are obvious
  task automatic load_directed();
    stim_row_t row;
    row.known = 1'b1;
    // No relative motion
    row.pair = make_pair(0, 0, 0, 0, 5, 2560, 0, 0, 0, 5);
    row.hit = 1'b0; row.contact_time = '0; row_q.push_back(row);
    // Head-on approach, contact after 8 s
    row.pair = make_pair(0, 0, 0, 0, 10, 25600, 0, -2560, 0, 10);
    row.hit = 1'b1; row.contact_time = 24'd524288; row_q.push_back(row);
    // Passing far off to the side: negative discriminant
    row.pair = make_pair(0, 0, 0, 0, 1, 256000, 0, 0, 256, 1);
    row.hit = 1'b0; row.contact_time = '0; row_q.push_back(row);
    // Moving apart: both roots negative
    row.pair = make_pair(0, 0, 0, 0, 2, 25600, 0, 2560, 0, 2);
    row.hit = 1'b0; row.contact_time = '0; row_q.push_back(row);
    // Grazing tangent pass
    row.pair = make_pair(0, 0, 0, 0, 10, 25600, 5120, -256, 0, 10);
    row.hit = 1'b0; row.contact_time = '0; row_q.push_back(row);
    // Everything else goes through the predictor
    row.known = 1'b0; row.hit = 1'b0; row.contact_time = '0;
    // Already overlapping, closing and separating
    row.pair = make_pair(0, 0, 0, 0, 50, 2560, 0, -256, 0, 50); row_q.push_back(row);
    row.pair = make_pair(0, 0, 0, 0, 50, 2560, 0, 256, 0, 50);  row_q.push_back(row);
    // Very slow approach from far away: saturated time
    row.pair = make_pair(-8388608, 0, 0, 0, 0, 8388607, 0, -1, 0, 0); row_q.push_back(row);
    row.pair = make_pair(-8388608, 0, 1, 0, 1023, 8388607, 0, 0, 0, 1023); row_q.push_back(row);
    // Field extremes
    row.pair = make_pair(-8388608, -8388608, -8388608, -8388608, 1023,
                         8388607, 8388607, 8388607, 8388607, 1023); row_q.push_back(row);
    row.pair = make_pair(8388607, 8388607, 8388607, 8388607, 0,
                         -8388608, -8388608, -8388608, -8388608, 0); row_q.push_back(row);
    row.pair = make_pair(-8388608, 8388607, 8388607, -8388608, 1023,
                         8388607, -8388608, -8388608, 8388607, 0); row_q.push_back(row);
    row.pair = make_pair(0, 0, -1, -1, 1023, 1, 1, 1, 1, 1023); row_q.push_back(row);
    // Zero radii, diagonal approach
    row.pair = make_pair(0, 0, 256, 256, 0, 25600, 25600, -256, -256, 0); row_q.push_back(row);
  endtask

  // Sink side: random stalls, short mostly, a few long
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toi_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      toi_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      toi_if.ready <= 1'b1;
      stall_left   <= gap_length();
    end
  end

  // Record accepted pairs and check every result transfer
  always @(posedge clk_i) begin
    contact_t exp_c;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && pair_if.valid && pair_if.ready) begin
      if (row_q.size() > 0 && row_q[0].known) begin
        exp_c.hit = row_q[0].hit;
        exp_c.contact_time = row_q[0].contact_time;
      end else begin
        exp_c = predict_contact({pair_if.first_x, pair_if.first_y, pair_if.first_vel_x,
                                 pair_if.first_vel_y, pair_if.first_radius,
                                 pair_if.second_x, pair_if.second_y, pair_if.second_vel_x,
                                 pair_if.second_vel_y, pair_if.second_radius});
      end
      if (row_q.size() > 0) void'(row_q.pop_front());
      contact_q.push_back(exp_c);
      pair_cnt <= pair_cnt + 1;
      if (exp_c.hit) hit_cnt <= hit_cnt + 1;
      if (exp_c.hit && exp_c.contact_time == TIME_SAT) sat_cnt <= sat_cnt + 1;
    end
    if (rst_ni && toi_if.valid && toi_if.ready) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b contact_time=%0d", $time,
                 toi_if.hit, toi_if.contact_time);
        error_cnt = error_cnt + 1;
      end else begin
        exp_c = contact_q.pop_front();
        if (toi_if.hit !== exp_c.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_c.hit, toi_if.hit);
          error_cnt = error_cnt + 1;
        end
        if (toi_if.contact_time !== exp_c.contact_time) begin
          $display("%0t: contact_time expected %0d actual %0d", $time,
                   exp_c.contact_time, toi_if.contact_time);
          error_cnt = error_cnt + 1;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold one pair until its transfer, then idle for a random gap
  task automatic send_pair(ctoi_pkg::ctoi_pair_t p);
    int gap;
    pair_if.valid         <= 1'b1;
    pair_if.first_x       <= p.first_x;
    pair_if.first_y       <= p.first_y;
    pair_if.first_vel_x   <= p.first_vel_x;
    pair_if.first_vel_y   <= p.first_vel_y;
    pair_if.first_radius  <= p.first_radius;
    pair_if.second_x      <= p.second_x;
    pair_if.second_y      <= p.second_y;
    pair_if.second_vel_x  <= p.second_vel_x;
    pair_if.second_vel_y  <= p.second_vel_y;
    pair_if.second_radius <= p.second_radius;
    do @(posedge clk_i); while (!pair_if.ready);
    gap = gap_length();
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    stim_row_t directed[$];
    pair_if.valid = 1'b0;
    {pair_if.first_x, pair_if.first_y, pair_if.first_vel_x, pair_if.first_vel_y,
     pair_if.first_radius, pair_if.second_x, pair_if.second_y, pair_if.second_vel_x,
     pair_if.second_vel_y, pair_if.second_radius} = '0;
    toi_if.ready = 1'b0;
    load_directed();
    directed = row_q;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed table, then random pairs
    foreach (directed[i]) send_pair(directed[i].pair);
    for (int i = 0; i < NUM_RANDOM; i++) send_pair(random_pair());
    pair_if.valid <= 1'b0;
    @(posedge clk_i);
    // Drain outstanding results
    while (contact_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d disk pairs (directed and random) under random stalls on both sides.",
             pair_cnt);
    $display("Expected %0d contacts, %0d of them saturated; %0d mismatches.",
             hit_cnt, sat_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ctoi_pkg.sv
sv/ctoi_in_if.sv
sv/ctoi_out_if.sv
sv/ctoi_front.sv
sv/ctoi_sqrt_cell.sv
sv/ctoi_div_cell.sv
sv/ctoi_check.sv
sv/circle_pair_time_of_impact_top.sv
tb/circle_pair_time_of_impact_top_tb.sv
